/* rtl/rddh_pkg.sv */
// ============================================================================
// rddh_pkg - shared types and constants for the dependency distance histogram
// Holds sizes, command, histogram and configuration codes, the per-register table entry,
// the histogram update request and the distance and saturating-increment helper functions.
// ============================================================================
`default_nettype none

package rddh_pkg;

    localparam int unsigned NUM_REGS  = 256;
    localparam int unsigned HIST_BINS = 1024;
    localparam int unsigned NUM_HIST  = 3;

    localparam int unsigned REG_AW    = $clog2(NUM_REGS);
    localparam int unsigned HIST_AW   = $clog2(HIST_BINS);
    localparam int unsigned CLEAR_LEN = (HIST_BINS > NUM_REGS) ? HIST_BINS : NUM_REGS;
    localparam int unsigned CLR_W     = $clog2(CLEAR_LEN);

    localparam int unsigned IDX_W     = 32;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned LIMIT_W   = 11;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned REG_ID_W  = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned BIN_W     = 10;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [REG_AW-1:0]  reg_addr_t;
    typedef logic [HIST_AW-1:0] hbin_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [LIMIT_W-1:0] limit_t;
    typedef logic [CLR_W-1:0]   clr_cnt_t;

    localparam limit_t LIMIT_RESET = limit_t'(1000);
    localparam idx_t   NO_INSTR    = '1;
    localparam idx_t   LAST_INSTR  = NO_INSTR - idx_t'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_NEW_INSTR = 2'd0,
        CMD_REG_WRITE = 2'd1,
        CMD_REG_READ  = 2'd2,
        CMD_QUERY     = 2'd3
    } cmd_t;

    localparam logic [KIND_W-1:0] KIND_RAW = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WAW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAR_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAW_LIMIT = 2'd2;

    typedef struct packed {
        idx_t w_idx;
        logic w_valid;
        logic w_cons;
        idx_t r_idx;
        logic r_valid;
        logic r_cons;
    } tbl_ent_t;

    typedef struct packed {
        logic  hit;
        hbin_t bin;
    } tally_t;

    typedef struct packed {
        logic [NUM_HIST-1:0]        inc;
        hbin_t [NUM_HIST-1:0]       bin;
        logic                       query;
        logic                       query_ok;
        logic [KIND_W-1:0]          kind;
    } hist_req_t;

    function automatic tally_t tally(idx_t prev, idx_t cur, limit_t limit);
        logic [IDX_W:0] diff;
        tally_t         t;
        diff  = {1'b0, cur} - {1'b0, prev};
        t.bin = diff[HIST_AW-1:0];
        t.hit = !diff[IDX_W] && (diff[IDX_W-1:0] != '0)
                && (diff[IDX_W-1:0] < idx_t'(limit))
                && (diff[IDX_W-1:0] < idx_t'(HIST_BINS));
        return t;
    endfunction

    function automatic cnt_t sat_inc(cnt_t v);
        return (v == '1) ? v : v + cnt_t'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/register_dependency_distance_histogram_core.sv */
// ============================================================================
// register_dependency_distance_histogram_core - dependency distance histograms
// Tracks per-register write and read marks in a table memory and counts RAW,
// WAR and WAW distances into three saturating histograms; answers bin queries.
// ============================================================================
// Throughput: one transaction per cycle; the pipe holds only when a query
//   reaches stage two while the previous result is still waiting on m_ready.
// Query path: a query result passes the table read, the histogram read and the
//   output register, in that order, before it shows on m_valid.
// Reset: a sweep over CLEAR_LEN (1024) addresses zeroes the register table and the
//   histograms; s_ready stays low until it ends, configuration writes still land.
`default_nettype none

module register_dependency_distance_histogram_core import rddh_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CMD_W-1:0]     s_cmd,
    input  wire logic [REG_ID_W-1:0]  s_reg_id,
    input  wire logic [KIND_W-1:0]    s_hist_kind,
    input  wire logic [BIN_W-1:0]     s_bin_index,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CNT_W-1:0]          m_bin_count,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0]   cfg_wdata
);

    limit_t raw_limit_reg, war_limit_reg, waw_limit_reg;
    idx_t   instr_index_reg;

    logic     clr_busy_reg;
    clr_cnt_t clr_cnt_reg;

    logic adv;
    logic acc;

    tbl_ent_t tbl_mem [NUM_REGS];
    tbl_ent_t tbl_rdata_reg;

    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    reg_addr_t         s1_addr_reg;
    logic              s1_reg_ok_reg;
    idx_t              s1_cur_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [BIN_W-1:0]  s1_bin_reg;

    logic      tfwd_valid_reg;
    reg_addr_t tfwd_addr_reg;
    tbl_ent_t  tfwd_ent_reg;

    tbl_ent_t  ent;
    tbl_ent_t  ent_next;
    logic      live;
    logic      tbl_we;
    limit_t    w_limit;
    tally_t    t_w;
    tally_t    t_r;
    hist_req_t req;

    logic bank_query;
    cnt_t bank_value;

    logic m_valid_reg;
    cnt_t m_bin_count_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_limit_reg <= LIMIT_RESET;
            war_limit_reg <= LIMIT_RESET;
            waw_limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RAW_LIMIT: raw_limit_reg <= cfg_wdata;
                CFG_WAR_LIMIT: war_limit_reg <= cfg_wdata;
                CFG_WAW_LIMIT: waw_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clear sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + clr_cnt_t'(1);
            if (clr_cnt_reg == clr_cnt_t'(CLEAR_LEN - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign adv     = !(bank_query && m_valid_reg && !m_ready);
    assign s_ready = adv && !clr_busy_reg;
    assign acc     = s_valid && s_ready;

    // instruction index, saturating
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            instr_index_reg <= NO_INSTR;
        end else if (acc && (cmd_t'(s_cmd) == CMD_NEW_INSTR)) begin
            if (instr_index_reg == NO_INSTR) begin
                instr_index_reg <= '0;
            end else if (instr_index_reg != LAST_INSTR) begin
                instr_index_reg <= instr_index_reg + idx_t'(1);
            end
        end
    end

    // stage one capture
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_cmd_reg    <= cmd_t'(s_cmd);
            s1_addr_reg   <= reg_addr_t'(s_reg_id);
            s1_reg_ok_reg <= idx_t'(s_reg_id) < idx_t'(NUM_REGS);
            s1_cur_reg    <= instr_index_reg;
            s1_kind_reg   <= s_hist_kind;
            s1_bin_reg    <= s_bin_index;
        end
    end

    // register table
    always_ff @(posedge aclk) begin
        if (adv) begin
            tbl_rdata_reg <= tbl_mem[reg_addr_t'(s_reg_id)];
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            tbl_mem[reg_addr_t'(clr_cnt_reg)] <= '0;
        end else if (adv && tbl_we) begin
            tbl_mem[s1_addr_reg] <= ent_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tfwd_valid_reg <= 1'b0;
        end else if (adv && tbl_we) begin
            tfwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && tbl_we) begin
            tfwd_addr_reg <= s1_addr_reg;
            tfwd_ent_reg  <= ent_next;
        end
    end

    // stage one: modify entry, build histogram request
    assign ent     = (tfwd_valid_reg && (tfwd_addr_reg == s1_addr_reg))
                     ? tfwd_ent_reg : tbl_rdata_reg;
    assign live    = s1_reg_ok_reg && (s1_cur_reg != NO_INSTR);
    assign w_limit = (s1_cmd_reg == CMD_REG_WRITE) ? waw_limit_reg : raw_limit_reg;
    assign t_w     = tally(ent.w_idx, s1_cur_reg, w_limit);
    assign t_r     = tally(ent.r_idx, s1_cur_reg, war_limit_reg);

    always_comb begin
        ent_next = ent;
        req      = '0;
        tbl_we   = 1'b0;
        if (s1_valid_reg) begin
            unique case (s1_cmd_reg)
                CMD_REG_WRITE: begin
                    if (live) begin
                        tbl_we                = 1'b1;
                        req.inc[KIND_WAW]     = ent.w_valid && t_w.hit;
                        req.bin[KIND_WAW]     = t_w.bin;
                        req.bin[KIND_WAR]     = t_r.bin;
                        if (ent.r_valid && !ent.r_cons) begin
                            req.inc[KIND_WAR] = t_r.hit;
                            ent_next.r_cons   = 1'b1;
                        end
                        ent_next.w_idx        = s1_cur_reg;
                        ent_next.w_valid      = 1'b1;
                        ent_next.w_cons       = 1'b0;
                    end
                end
                CMD_REG_READ: begin
                    if (live) begin
                        tbl_we                = 1'b1;
                        req.bin[KIND_RAW]     = t_w.bin;
                        if (ent.w_valid && !ent.w_cons) begin
                            req.inc[KIND_RAW] = t_w.hit;
                            ent_next.w_cons   = 1'b1;
                        end
                        ent_next.r_idx        = s1_cur_reg;
                        ent_next.r_valid      = 1'b1;
                        ent_next.r_cons       = 1'b0;
                    end
                end
                CMD_QUERY: begin
                    req.query         = 1'b1;
                    req.query_ok      = idx_t'(s1_bin_reg) < idx_t'(HIST_BINS);
                    req.kind          = s1_kind_reg;
                    req.bin[KIND_RAW] = hbin_t'(s1_bin_reg);
                    req.bin[KIND_WAR] = hbin_t'(s1_bin_reg);
                    req.bin[KIND_WAW] = hbin_t'(s1_bin_reg);
                end
                CMD_NEW_INSTR: ;
            endcase
        end
    end

    rddh_hist_bank u_hist_bank (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .req      (req),
        .clr_en   (clr_busy_reg),
        .clr_addr (hbin_t'(clr_cnt_reg)),
        .s2_query (bank_query),
        .q_value  (bank_value)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && bank_query) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && bank_query) begin
            m_bin_count_reg <= bank_value;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_count = m_bin_count_reg;

    // checks
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !acc)
        else $error("transaction accepted during clear sweep");

    a_index_stays_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (instr_index_reg != NO_INSTR) |=> (instr_index_reg != NO_INSTR))
        else $error("instruction index fell back to none");

    a_query_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (bank_query && !adv) |=> bank_query)
        else $error("stalled query lost from stage two");

    a_one_kind_per_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.inc[KIND_RAW] && (req.inc[KIND_WAW] || req.inc[KIND_WAR])))
        else $error("read and write histogram updates in one transaction");

endmodule

`default_nettype wire

/* rtl/rddh_hist_bank.sv */
// ============================================================================
// rddh_hist_bank - RAW, WAR and WAW histogram memories
// One synchronous memory per histogram. Stage one issues the read, stage two
// increments with saturation and writes back, with a one-entry forward path
// for back-to-back updates of the same bin. Queries read out in stage two.
// ============================================================================
`default_nettype none

module rddh_hist_bank import rddh_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      adv,
    input  wire hist_req_t req,
    input  wire logic      clr_en,
    input  wire hbin_t     clr_addr,
    output logic           s2_query,
    output cnt_t           q_value
);

    hist_req_t s2_req_reg;
    cnt_t      eff [NUM_HIST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_req_reg <= '0;
        end else if (adv) begin
            s2_req_reg <= req;
        end
    end

    for (genvar k = 0; k < NUM_HIST; k++) begin : gen_hist
        cnt_t  mem [HIST_BINS];
        cnt_t  rdata_reg;
        logic  fwd_valid_reg;
        hbin_t fwd_bin_reg;
        cnt_t  fwd_data_reg;
        cnt_t  upd;

        assign eff[k] = (fwd_valid_reg && (fwd_bin_reg == s2_req_reg.bin[k]))
                        ? fwd_data_reg : rdata_reg;
        assign upd    = sat_inc(eff[k]);

        always_ff @(posedge aclk) begin
            if (clr_en) begin
                mem[clr_addr] <= '0;
            end else if (adv && s2_req_reg.inc[k]) begin
                mem[s2_req_reg.bin[k]] <= upd;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rdata_reg <= mem[req.bin[k]];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fwd_valid_reg <= 1'b0;
            end else if (adv && s2_req_reg.inc[k]) begin
                fwd_valid_reg <= 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv && s2_req_reg.inc[k]) begin
                fwd_bin_reg  <= s2_req_reg.bin[k];
                fwd_data_reg <= upd;
            end
        end
    end

    always_comb begin
        q_value = '0;
        if (s2_req_reg.query_ok) begin
            unique case (s2_req_reg.kind)
                KIND_RAW: q_value = eff[KIND_RAW];
                KIND_WAR: q_value = eff[KIND_WAR];
                KIND_WAW: q_value = eff[KIND_WAW];
                default:  q_value = '0;
            endcase
        end
    end

    assign s2_query = s2_req_reg.query;

endmodule

`default_nettype wire
